[design/qasf_pkg.sv]
// Shared widths, gains and types of the quaternion attitude feedback core.
package qasf_pkg;

    // Field widths.
    localparam int DataW = 16;
    localparam int AxisN = 3;

    // Square root of a Q28 radicand gives a Q14 root of up to 2^14.
    localparam int SqrtRootW = 15;
    localparam int SqrtRadW  = 2 * SqrtRootW;

    // Q1.0 in Q28, the limit on the squared vector length.
    localparam logic [SqrtRadW-1:0] OneQ28 = SqrtRadW'(1) << 28;

    // Configuration register indexes.
    localparam int CfgAddrW = 2;
    localparam logic [CfgAddrW-1:0] CfgRefW = 2'd0;
    localparam logic [CfgAddrW-1:0] CfgRefX = 2'd1;
    localparam logic [CfgAddrW-1:0] CfgRefY = 2'd2;
    localparam logic [CfgAddrW-1:0] CfgRefZ = 2'd3;

    // Reset values of the reference quaternion.
    localparam logic signed [DataW-1:0] RefWReset = 16'sd16384;

    // Gains in Q.20, rounded to nearest.
    localparam int GainKW  = 25;
    localparam int GainFbW = 20;
    localparam logic signed [GainKW-1:0] GainK [AxisN] = '{
        25'sd10434149, 25'sd10489652, 25'sd14365393
    };
    localparam logic signed [GainFbW-1:0] GainRate [AxisN] = '{
        20'sd469829, 20'sd475848, 20'sd330840
    };
    // The z axis adds its speed term, so its gain enters with a minus sign.
    localparam logic signed [GainFbW-1:0] GainSpeed [AxisN] = '{
        20'sd23652, 20'sd22981, -20'sd8030
    };

    // Axis neighbors used by the quaternion cross terms.
    localparam logic [1:0] NextAx [AxisN] = '{2'd1, 2'd2, 2'd0};
    localparam logic [1:0] PrevAx [AxisN] = '{2'd2, 2'd0, 2'd1};

    // Arithmetic widths of the feedback path.
    localparam int ProdW = 2 * DataW;            // Q28 quaternion products
    localparam int FbProdW = DataW + GainFbW;    // rate and speed times gain
    localparam int CrossW = ProdW + 2;           // sum of four products
    localparam int FbSumW = FbProdW + 1;
    localparam int LoW = 17;                     // low slice of the cross sum
    localparam int HiW = CrossW - LoW;
    localparam int KHiW = GainKW + HiW;
    localparam int KLoW = GainKW + LoW + 1;
    localparam int AccW = 60;                    // Q48 accumulator
    localparam int RoundShift = 40;
    localparam int RoundW = AccW - RoundShift;

    // One estimated state sample.
    typedef struct packed {
        logic [AxisN-1:0][DataW-1:0] quat;
        logic [AxisN-1:0][DataW-1:0] rate;
        logic [AxisN-1:0][DataW-1:0] speed;
    } t_sample;

endpackage

[design/qasf_sqrt.sv]
// Pipelined integer square root, one root bit resolved in each stage.
module qasf_sqrt
    import qasf_pkg::*;
#(
    parameter int RootW = SqrtRootW
) (
    input  logic                   i_clk,
    input  logic [2*RootW-1:0]     i_rad,
    output logic [RootW-1:0]       o_root
);

    localparam int RadW = 2 * RootW;

    // Partial root and remainder (radicand minus root squared) per stage.
    logic [RadW-1:0]  r_rem  [RootW];
    logic [RootW-1:0] r_root [RootW];

    for (genvar s = 0; s < RootW; s++) begin : g_stage
        localparam int Bit = RootW - 1 - s;
        logic [RadW-1:0]  rem_in;
        logic [RootW-1:0] root_in;
        logic [RadW-1:0]  trial;
        logic [RadW-1:0]  n_rem;
        logic [RootW-1:0] n_root;

        if (s == 0) begin : g_first
            assign rem_in  = i_rad;
            assign root_in = '0;
        end else begin : g_next
            assign rem_in  = r_rem[s-1];
            assign root_in = r_root[s-1];
        end

        // Setting this bit grows the square by 2^(Bit+1)*root + 2^(2*Bit).
        always_comb begin
            trial  = (RadW'(root_in) << (Bit + 1)) + (RadW'(1) << (2 * Bit));
            n_rem  = rem_in;
            n_root = root_in;
            if (rem_in >= trial) begin
                n_rem  = rem_in - trial;
                n_root = root_in | (RootW'(1) << Bit);
            end
        end

        always_ff @(posedge i_clk) begin
            r_rem[s]  <= n_rem;
            r_root[s] <= n_root;
        end
    end

    assign o_root = r_root[RootW-1];

endmodule

[design/quaternion_attitude_state_feedback_core.sv]
// Top level of the quaternion attitude state feedback core.
//
//   channel   direction  handshake              word
//   config    in         i_cfg_we               i_cfg_addr, i_cfg_data
//   sample    in         start, busy            i_quat_*, i_rate_*, i_speed_*
//   torque    out        o_strobe               o_torque_x, o_torque_y, o_torque_z
//
// A new word can be started in every cycle; busy is high only during reset.
// The torque word of a sample passes 23 register stages from the edge that
// accepts it; the 15-stage square root of the scalar part makes up most of them.
// The pipeline never stalls; the receiver must take every torque word in the
// cycle its strobe is high, which the block itself does not enforce. Reset
// clears the valid bits and sets the reference to w = 1.0, x = y = z = 0.
module quaternion_attitude_state_feedback_core
    import qasf_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_we,
    input  logic [CfgAddrW-1:0]      i_cfg_addr,
    input  logic [DataW-1:0]         i_cfg_data,
    input  logic                     start,
    output logic                     busy,
    input  logic signed [DataW-1:0]  i_quat_x,
    input  logic signed [DataW-1:0]  i_quat_y,
    input  logic signed [DataW-1:0]  i_quat_z,
    input  logic signed [DataW-1:0]  i_rate_x,
    input  logic signed [DataW-1:0]  i_rate_y,
    input  logic signed [DataW-1:0]  i_rate_z,
    input  logic signed [DataW-1:0]  i_speed_x,
    input  logic signed [DataW-1:0]  i_speed_y,
    input  logic signed [DataW-1:0]  i_speed_z,
    output logic                     o_strobe,
    output logic signed [DataW-1:0]  o_torque_x,
    output logic signed [DataW-1:0]  o_torque_y,
    output logic signed [DataW-1:0]  o_torque_z
);

    // Sample delay line: capture, squares, radicand, then the root stages.
    localparam int RootDone = 2 + SqrtRootW;
    localparam int DlyN = RootDone + 1;

    logic accept;
    assign busy   = ~i_rst_n;
    assign accept = start & ~busy;

    // Reference quaternion registers.
    logic signed [DataW-1:0] r_ref [AxisN];
    logic signed [DataW-1:0] r_ref_w;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ref_w <= RefWReset;
            for (int a = 0; a < AxisN; a++) begin
                r_ref[a] <= '0;
            end
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                CfgRefW: r_ref_w  <= i_cfg_data;
                CfgRefX: r_ref[0] <= i_cfg_data;
                CfgRefY: r_ref[1] <= i_cfg_data;
                CfgRefZ: r_ref[2] <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Valid bits of every stage.
    logic [DlyN-1:0] r_vld;
    logic            r_v_prod;
    logic            r_v_sum;
    logic            r_v_gain;
    logic            r_v_acc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld    <= '0;
            r_v_prod <= 1'b0;
            r_v_sum  <= 1'b0;
            r_v_gain <= 1'b0;
            r_v_acc  <= 1'b0;
            o_strobe <= 1'b0;
        end else begin
            r_vld    <= {r_vld[DlyN-2:0], accept};
            r_v_prod <= r_vld[RootDone];
            r_v_sum  <= r_v_prod;
            r_v_gain <= r_v_sum;
            r_v_acc  <= r_v_gain;
            o_strobe <= r_v_acc;
        end
    end

    // Input word and its delay line alongside the square root.
    t_sample r_smp [DlyN];
    t_sample in_smp;

    always_comb begin
        in_smp.quat  = {i_quat_z, i_quat_y, i_quat_x};
        in_smp.rate  = {i_rate_z, i_rate_y, i_rate_x};
        in_smp.speed = {i_speed_z, i_speed_y, i_speed_x};
    end

    always_ff @(posedge i_clk) begin
        r_smp[0] <= in_smp;
        for (int d = 1; d < DlyN; d++) begin
            r_smp[d] <= r_smp[d-1];
        end
    end

    // Squares of the vector part.
    logic [ProdW-2:0] r_sq [AxisN];

    always_ff @(posedge i_clk) begin
        for (int a = 0; a < AxisN; a++) begin
            r_sq[a] <= (ProdW-1)'(ProdW'(signed'(r_smp[0].quat[a]))
                                * ProdW'(signed'(r_smp[0].quat[a])));
        end
    end

    // Radicand 1 - |v|^2 in Q28, zero where the vector is not shorter than one.
    logic [ProdW-1:0]    norm;
    logic [SqrtRadW-1:0] r_rad;

    assign norm = ProdW'(r_sq[0]) + ProdW'(r_sq[1]) + ProdW'(r_sq[2]);

    always_ff @(posedge i_clk) begin
        if (norm < ProdW'(OneQ28)) begin
            r_rad <= OneQ28 - SqrtRadW'(norm);
        end else begin
            r_rad <= '0;
        end
    end

    logic [SqrtRootW-1:0] root;

    qasf_sqrt #(
        .RootW (SqrtRootW)
    ) u_sqrt (
        .i_clk  (i_clk),
        .i_rad  (r_rad),
        .o_root (root)
    );

    // Cross products and feedback products.
    t_sample                   smp_root;
    logic signed [DataW-1:0]   q0;
    logic signed [ProdW-1:0]   r_p [AxisN][4];
    logic signed [FbProdW-1:0] r_fr [AxisN];
    logic signed [FbProdW-1:0] r_fs [AxisN];

    assign smp_root = r_smp[RootDone];
    assign q0       = signed'({1'b0, root});

    always_ff @(posedge i_clk) begin
        for (int a = 0; a < AxisN; a++) begin
            r_p[a][0] <= r_ref[PrevAx[a]] * signed'(smp_root.quat[NextAx[a]]);
            r_p[a][1] <= r_ref_w * signed'(smp_root.quat[a]);
            r_p[a][2] <= r_ref[NextAx[a]] * signed'(smp_root.quat[PrevAx[a]]);
            r_p[a][3] <= r_ref[a] * q0;
            r_fr[a]   <= signed'(smp_root.rate[a]) * GainRate[a];
            r_fs[a]   <= signed'(smp_root.speed[a]) * GainSpeed[a];
        end
    end

    // Cross sums and feedback sums.
    logic signed [CrossW-1:0] r_c [AxisN];
    logic signed [FbSumW-1:0] r_f [AxisN];

    always_ff @(posedge i_clk) begin
        for (int a = 0; a < AxisN; a++) begin
            r_c[a] <= CrossW'(r_p[a][0]) - CrossW'(r_p[a][1])
                    - CrossW'(r_p[a][2]) + CrossW'(r_p[a][3]);
            r_f[a] <= FbSumW'(r_fr[a]) + FbSumW'(r_fs[a]);
        end
    end

    // Gain times cross sum, split into a high and a low partial product.
    logic signed [KHiW-1:0]   r_kh [AxisN];
    logic signed [KLoW-1:0]   r_kl [AxisN];
    logic signed [FbSumW-1:0] r_f2 [AxisN];

    always_ff @(posedge i_clk) begin
        for (int a = 0; a < AxisN; a++) begin
            r_kh[a] <= GainK[a] * signed'(r_c[a][CrossW-1:LoW]);
            r_kl[a] <= GainK[a] * signed'({1'b0, r_c[a][LoW-1:0]});
            r_f2[a] <= r_f[a];
        end
    end

    // Q48 accumulation.
    logic signed [AccW-1:0] r_acc [AxisN];

    always_ff @(posedge i_clk) begin
        for (int a = 0; a < AxisN; a++) begin
            r_acc[a] <= (AccW'(r_kh[a]) <<< LoW) + AccW'(r_kl[a])
                      - (AccW'(r_f2[a]) <<< 20);
        end
    end

    // Round half up to Q8.8 and saturate.
    logic signed [DataW-1:0] n_torque [AxisN];

    always_comb begin
        logic signed [AccW-1:0]   t;
        logic signed [RoundW-1:0] r;
        for (int a = 0; a < AxisN; a++) begin
            t = r_acc[a] + (AccW'(1) <<< (RoundShift - 1));
            r = signed'(t[AccW-1:RoundShift]);
            if (r > RoundW'(32767)) begin
                n_torque[a] = 16'sh7FFF;
            end else if (r < -RoundW'(32768)) begin
                n_torque[a] = -16'sh8000;
            end else begin
                n_torque[a] = r[DataW-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        o_torque_x <= n_torque[0];
        o_torque_y <= n_torque[1];
        o_torque_z <= n_torque[2];
    end

endmodule
